[design/qslerp_pkg.sv]
// Shared constants, types and tables for the quaternion slerp pipeline.
`timescale 1ns / 1ps

package qslerp_pkg;

    // Number formats.
    localparam int FRAC_BITS   = 14;
    localparam int TRIG_FRAC   = 30;
    localparam int CORDIC_ITER = 30;
    localparam int SQRT_STEPS  = 31;
    localparam int DIV_STEPS   = 16;
    localparam int MAG_SHIFT   = TRIG_FRAC - 2 * FRAC_BITS;
    localparam int LIM_SHIFT   = TRIG_FRAC - FRAC_BITS;

    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam logic [31:0] Q30_PI      = 32'd3373259426;
    localparam logic [31:0] Q30_HALF_PI = 32'd1686629713;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [14:0] BLEND_ONE   = 15'd16384;

    // Pipeline stage numbers.
    localparam int ST_IN    = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_DOT   = 2;
    localparam int ST_SQ    = 3;
    localparam int ST_SQRT0 = 4;
    localparam int ST_SN    = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_TH    = ST_SN + CORDIC_ITER;
    localparam int ST_ANG   = ST_TH + 1;
    localparam int ST_ROT0  = ST_ANG + 1;
    localparam int ST_MIX   = ST_ROT0 + CORDIC_ITER;
    localparam int ST_NUM   = ST_MIX + 1;
    localparam int ST_DIV0  = ST_NUM + 1;
    localparam int ST_OUT   = ST_DIV0 + DIV_STEPS;
    localparam int N_STAGES = ST_OUT + 1;

    typedef enum logic {
        CORDIC_VECTOR,
        CORDIC_ROTATE
    } cordic_mode_t;

    // Per-item data that travels alongside the arithmetic cells.
    typedef struct packed {
        logic [3:0][15:0] s;
        logic [3:0][15:0] f;
        logic [14:0]      blend;
        logic             neg;
        logic [30:0]      mag;
        logic [30:0]      sn;
        logic             degen;
        logic [31:0]      theta;
        logic [14:0]      t;
        logic [14:0]      u;
        logic [3:0]       nneg;
        logic [3:0]       ovf;
    } side_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'd843314857;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043837;
            5'd3:  r = 30'd133525159;
            5'd4:  r = 30'd67021687;
            5'd5:  r = 30'd33543516;
            5'd6:  r = 30'd16775851;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194283;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048576;
            5'd11: r = 30'd524288;
            5'd12: r = 30'd262144;
            5'd13: r = 30'd131072;
            5'd14: r = 30'd65536;
            5'd15: r = 30'd32768;
            5'd16: r = 30'd16384;
            5'd17: r = 30'd8192;
            5'd18: r = 30'd4096;
            5'd19: r = 30'd2048;
            5'd20: r = 30'd1024;
            5'd21: r = 30'd512;
            5'd22: r = 30'd256;
            5'd23: r = 30'd128;
            5'd24: r = 30'd64;
            5'd25: r = 30'd32;
            5'd26: r = 30'd16;
            5'd27: r = 30'd8;
            5'd28: r = 30'd4;
            5'd29: r = 30'd2;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

[design/qslerp_sqrt_cell.sv]
// One digit step of the pipelined integer square root.
`timescale 1ns / 1ps

module qslerp_sqrt_cell (
    input  logic        aclk,
    input  logic        en,
    input  logic [32:0] rem_in,
    input  logic [30:0] root_in,
    input  logic [61:0] rad_in,
    output logic [32:0] rem_out,
    output logic [30:0] root_out,
    output logic [61:0] rad_out
);
    logic [32:0] rem_reg, rem_next;
    logic [30:0] root_reg, root_next;
    logic [61:0] rad_reg;
    logic [34:0] cat;
    logic [34:0] trial;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        cat   = {rem_in, rad_in[61:60]};
        trial = {2'b00, root_in, 2'b01};
        if (cat >= trial) begin
            rem_next  = 33'(cat - trial);
            root_next = {root_in[29:0], 1'b1};
        end else begin
            rem_next  = cat[32:0];
            root_next = {root_in[29:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= {rad_in[59:0], 2'b00};
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

[design/qslerp_cordic_cell.sv]
// One CORDIC micro-rotation, usable in vectoring or rotation mode.
`timescale 1ns / 1ps

module qslerp_cordic_cell (
    input  logic                      aclk,
    input  logic                      en,
    input  qslerp_pkg::cordic_mode_t  mode,
    input  logic [4:0]                idx,
    input  logic signed [33:0]        x_in,
    input  logic signed [33:0]        y_in,
    input  logic signed [32:0]        z_in,
    output logic signed [33:0]        x_out,
    output logic signed [33:0]        y_out,
    output logic signed [32:0]        z_out
);
    import qslerp_pkg::*;

    logic signed [33:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [32:0] z_reg, z_next, ang;
    logic               turn_pos;

    // Pick the direction, then shift-and-add.
    always_comb begin
        dx  = y_in >>> idx;
        dy  = x_in >>> idx;
        ang = $signed({3'b000, atan_q30(idx)});
        if (mode == CORDIC_ROTATE) begin
            turn_pos = (z_in >= 0);
        end else begin
            turn_pos = (y_in < 0);
        end
        if (turn_pos) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ang;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

[design/qslerp_div_cell.sv]
// One quotient bit of the pipelined restoring divider.
`timescale 1ns / 1ps

module qslerp_div_cell (
    input  logic        aclk,
    input  logic        en,
    input  logic [3:0]  idx,
    input  logic [30:0] den,
    input  logic [47:0] rem_in,
    input  logic [15:0] quo_in,
    output logic [47:0] rem_out,
    output logic [15:0] quo_out
);
    logic [47:0] rem_reg, rem_next, den_sh;
    logic [15:0] quo_reg, quo_next;

    // Subtract the shifted divisor when it fits.
    always_comb begin
        den_sh = {17'd0, den} << idx;
        if (rem_in >= den_sh) begin
            rem_next = rem_in - den_sh;
            quo_next = quo_in | (16'd1 << idx);
        end else begin
            rem_next = rem_in;
            quo_next = quo_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

[design/quaternion_slerp_unit.sv]
// Top level of the fixed-point quaternion slerp pipeline.
//
//  Channel   Direction  Handshake               Content
//  s_*       in         s_tvalid / s_tready     start, finish, blend
//  m_*       out        m_tvalid / m_tready     interpolated quaternion, degenerate
//  cfg_*     in         cfg_valid / cfg_ready   small_angle_limit
//
// One request enters per cycle unless a result waits at the output unaccepted.
// Depth is set by the cell rows: 31 square-root cells, 30 vectoring CORDIC cells,
// 30 cells in each rotation row and 16 in each divider row, plus nine arithmetic stages.
// The whole pipeline advances together; it holds only while a result waits.
// Reset clears the stage valid bits and sets the limit to 16; no clearing pass.
`timescale 1ns / 1ps

module quaternion_slerp_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_w, start_x, start_y, start_z, finish_w, finish_x, finish_y, finish_z,
    // blend (15 bits), one pad bit
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_w, out_x, out_y, out_z
    output logic [63:0]  m_tdata,
    // degenerate
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [12:0]  cfg_data
);
    import qslerp_pkg::*;

    logic        adv;
    logic [12:0] limit_reg;
    logic        vld_reg  [0:N_STAGES-1];
    side_t       side_reg [0:N_STAGES-1];
    side_t       side_next [0:N_STAGES-1];

    logic signed [31:0] prod_reg [0:3];
    logic [61:0]        magsq_reg;

    logic [32:0] sq_rem  [0:SQRT_STEPS-1];
    logic [30:0] sq_root [0:SQRT_STEPS-1];
    logic [61:0] sq_rad  [0:SQRT_STEPS-1];

    logic signed [33:0] vx [0:CORDIC_ITER-1];
    logic signed [33:0] vy [0:CORDIC_ITER-1];
    logic signed [32:0] vz [0:CORDIC_ITER-1];
    logic signed [33:0] ax [0:CORDIC_ITER-1];
    logic signed [33:0] ay [0:CORDIC_ITER-1];
    logic signed [32:0] az [0:CORDIC_ITER-1];
    logic signed [33:0] bx [0:CORDIC_ITER-1];
    logic signed [33:0] by [0:CORDIC_ITER-1];
    logic signed [32:0] bz [0:CORDIC_ITER-1];

    logic [30:0] ang_a_reg, ang_b_reg;
    logic signed [47:0] mix_reg [0:7];
    logic [47:0] num_reg [0:3];
    logic [47:0] dv_rem [0:3][0:DIV_STEPS-1];
    logic [15:0] dv_quo [0:3][0:DIV_STEPS-1];

    logic [63:0] out_reg;
    logic        degen_reg;

    // Stage combinational results.
    logic signed [33:0] dot;
    logic [32:0]        dot_mag;
    logic [30:0]        mag_q30;
    logic [30:0]        sn;
    logic [28:0]        lim;
    logic signed [33:0] theta_raw;
    logic [31:0]        theta_c;
    logic [14:0]        t_c;
    logic [46:0]        pa, pb;
    logic [31:0]        aa, ab;
    logic [30:0]        sa, sb;
    logic signed [48:0] num_s [0:3];
    logic [47:0]        num_m [0:3];
    logic [47:0]        num_r [0:3];
    logic [3:0]         ovf_c;
    logic [3:0][15:0]   res_c;

    assign adv       = !vld_reg[ST_OUT] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[ST_OUT];
    assign m_tdata   = out_reg;
    assign m_tuser   = degen_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 13'd16;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < N_STAGES; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Dot product magnitude, moved to Q30.
    always_comb begin
        dot = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        dot_mag = (dot < 0) ? 33'(-dot) : 33'(dot);
        if (dot_mag >= (33'd1 << (2 * FRAC_BITS))) begin
            mag_q30 = Q30_ONE;
        end else begin
            mag_q30 = 31'(dot_mag << MAG_SHIFT);
        end
    end

    // Small-angle test on sin theta.
    always_comb begin
        sn  = sq_root[SQRT_STEPS-1];
        lim = {limit_reg, 16'd0};
    end

    // Angle fix-up, blend clamp and the two scaled angles.
    always_comb begin
        if (side_reg[ST_TH-1].neg) begin
            theta_raw = $signed({2'b00, Q30_PI}) - 34'(vz[CORDIC_ITER-1]);
        end else begin
            theta_raw = 34'(vz[CORDIC_ITER-1]);
        end
        if (theta_raw < 0) begin
            theta_c = 32'd0;
        end else if (theta_raw > $signed({2'b00, Q30_PI})) begin
            theta_c = Q30_PI;
        end else begin
            theta_c = theta_raw[31:0];
        end
        t_c = (side_reg[ST_TH-1].blend > BLEND_ONE) ? BLEND_ONE : side_reg[ST_TH-1].blend;
        pa = side_reg[ST_ANG-1].u * side_reg[ST_ANG-1].theta;
        pb = side_reg[ST_ANG-1].t * side_reg[ST_ANG-1].theta;
        aa = pa[FRAC_BITS+31:FRAC_BITS];
        ab = pb[FRAC_BITS+31:FRAC_BITS];
    end

    // Sine clamps to [0, 1].
    always_comb begin
        if (ay[CORDIC_ITER-1] < 0) begin
            sa = 31'd0;
        end else if (ay[CORDIC_ITER-1] > $signed({3'b000, Q30_ONE})) begin
            sa = Q30_ONE;
        end else begin
            sa = ay[CORDIC_ITER-1][30:0];
        end
        if (by[CORDIC_ITER-1] < 0) begin
            sb = 31'd0;
        end else if (by[CORDIC_ITER-1] > $signed({3'b000, Q30_ONE})) begin
            sb = Q30_ONE;
        end else begin
            sb = by[CORDIC_ITER-1][30:0];
        end
    end

    // Numerators, magnitudes with the rounding half added, overflow check.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            num_s[k] = 49'(mix_reg[k]) + 49'(mix_reg[k+4]);
            num_m[k] = (num_s[k] < 0) ? 48'(-num_s[k]) : 48'(num_s[k]);
            num_r[k] = num_m[k] + 48'(side_reg[ST_NUM-1].sn >> 1);
            ovf_c[k] = num_r[k] >= {1'b0, side_reg[ST_NUM-1].sn, 16'd0};
        end
    end

    // Final sign, saturation and degenerate bypass.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (side_reg[ST_OUT-1].degen) begin
                res_c[k] = side_reg[ST_OUT-1].s[k];
            end else if (side_reg[ST_OUT-1].nneg[k]) begin
                if (side_reg[ST_OUT-1].ovf[k] || dv_quo[k][DIV_STEPS-1] > 16'd32768) begin
                    res_c[k] = 16'h8000;
                end else begin
                    res_c[k] = 16'(-dv_quo[k][DIV_STEPS-1]);
                end
            end else begin
                if (side_reg[ST_OUT-1].ovf[k] || dv_quo[k][DIV_STEPS-1] > 16'd32767) begin
                    res_c[k] = 16'h7FFF;
                end else begin
                    res_c[k] = dv_quo[k][DIV_STEPS-1];
                end
            end
        end
    end

    // Side data for the next cycle: each stage takes its neighbor's copy,
    // with the fields that a stage computes filled in on the way.
    always_comb begin
        side_next[0] = '0;
        for (int k = 0; k < 4; k++) begin
            side_next[0].s[k] = s_tdata[16*k +: 16];
            side_next[0].f[k] = s_tdata[64 + 16*k +: 16];
        end
        side_next[0].blend = s_tdata[142:128];
        for (int i = 1; i < N_STAGES; i++) begin
            side_next[i] = side_reg[i-1];
        end
        side_next[ST_DOT].neg  = (dot < 0);
        side_next[ST_DOT].mag  = mag_q30;
        side_next[ST_SN].sn    = sn;
        side_next[ST_SN].degen = (sn == 31'd0) || (sn < {2'b00, lim});
        side_next[ST_TH].theta = theta_c;
        side_next[ST_TH].t     = t_c;
        side_next[ST_TH].u     = BLEND_ONE - t_c;
        for (int k = 0; k < 4; k++) begin
            side_next[ST_NUM].nneg[k] = num_s[k] < 0;
        end
        side_next[ST_NUM].ovf = ovf_c;
    end

    // Side data and stage registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N_STAGES; i++) begin
                side_reg[i] <= side_next[i];
            end
            for (int k = 0; k < 4; k++) begin
                prod_reg[k] <= $signed(side_reg[ST_PROD-1].s[k])
                               * $signed(side_reg[ST_PROD-1].f[k]);
                mix_reg[k]   <= $signed(side_reg[ST_MIX-1].s[k]) * $signed({1'b0, sa});
                mix_reg[k+4] <= $signed(side_reg[ST_MIX-1].f[k]) * $signed({1'b0, sb});
                num_reg[k]   <= num_r[k];
            end
            magsq_reg <= side_reg[ST_SQ-1].mag * side_reg[ST_SQ-1].mag;
            ang_a_reg <= (aa > Q30_HALF_PI) ? 31'(Q30_PI - aa) : aa[30:0];
            ang_b_reg <= (ab > Q30_HALF_PI) ? 31'(Q30_PI - ab) : ab[30:0];
            out_reg   <= res_c;
            degen_reg <= side_reg[ST_OUT-1].degen;
        end
    end

    // Square-root row.
    for (genvar c = 0; c < SQRT_STEPS; c++) begin : g_sqrt
        if (c == 0) begin : g_first
            qslerp_sqrt_cell u_cell (
                .aclk     (aclk),
                .en       (adv),
                .rem_in   (33'd0),
                .root_in  (31'd0),
                .rad_in   ({1'b0, 61'((62'd1 << 60) - magsq_reg)}),
                .rem_out  (sq_rem[c]),
                .root_out (sq_root[c]),
                .rad_out  (sq_rad[c])
            );
        end else begin : g_next
            qslerp_sqrt_cell u_cell (
                .aclk     (aclk),
                .en       (adv),
                .rem_in   (sq_rem[c-1]),
                .root_in  (sq_root[c-1]),
                .rad_in   (sq_rad[c-1]),
                .rem_out  (sq_rem[c]),
                .root_out (sq_root[c]),
                .rad_out  (sq_rad[c])
            );
        end
    end

    // Vectoring row for theta and the two rotation rows for the sines.
    for (genvar j = 0; j < CORDIC_ITER; j++) begin : g_cordic
        if (j == 0) begin : g_first
            qslerp_cordic_cell u_vec (
                .aclk (aclk), .en (adv), .mode (CORDIC_VECTOR), .idx (5'(j)),
                .x_in ({3'b000, side_reg[ST_SN-1].mag}), .y_in ({3'b000, sn}),
                .z_in (33'sd0),
                .x_out (vx[j]), .y_out (vy[j]), .z_out (vz[j])
            );
            qslerp_cordic_cell u_rot_a (
                .aclk (aclk), .en (adv), .mode (CORDIC_ROTATE), .idx (5'(j)),
                .x_in (CORDIC_GAIN), .y_in (34'sd0), .z_in ({2'b00, ang_a_reg}),
                .x_out (ax[j]), .y_out (ay[j]), .z_out (az[j])
            );
            qslerp_cordic_cell u_rot_b (
                .aclk (aclk), .en (adv), .mode (CORDIC_ROTATE), .idx (5'(j)),
                .x_in (CORDIC_GAIN), .y_in (34'sd0), .z_in ({2'b00, ang_b_reg}),
                .x_out (bx[j]), .y_out (by[j]), .z_out (bz[j])
            );
        end else begin : g_next
            qslerp_cordic_cell u_vec (
                .aclk (aclk), .en (adv), .mode (CORDIC_VECTOR), .idx (5'(j)),
                .x_in (vx[j-1]), .y_in (vy[j-1]), .z_in (vz[j-1]),
                .x_out (vx[j]), .y_out (vy[j]), .z_out (vz[j])
            );
            qslerp_cordic_cell u_rot_a (
                .aclk (aclk), .en (adv), .mode (CORDIC_ROTATE), .idx (5'(j)),
                .x_in (ax[j-1]), .y_in (ay[j-1]), .z_in (az[j-1]),
                .x_out (ax[j]), .y_out (ay[j]), .z_out (az[j])
            );
            qslerp_cordic_cell u_rot_b (
                .aclk (aclk), .en (adv), .mode (CORDIC_ROTATE), .idx (5'(j)),
                .x_in (bx[j-1]), .y_in (by[j-1]), .z_in (bz[j-1]),
                .x_out (bx[j]), .y_out (by[j]), .z_out (bz[j])
            );
        end
    end

    // Divider rows, one per component, most significant quotient bit first.
    for (genvar k = 0; k < 4; k++) begin : g_div_lane
        for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
            if (j == 0) begin : g_first
                qslerp_div_cell u_cell (
                    .aclk (aclk), .en (adv), .idx (4'(DIV_STEPS - 1 - j)),
                    .den (side_reg[ST_DIV0-1+j].sn),
                    .rem_in (num_reg[k]), .quo_in (16'd0),
                    .rem_out (dv_rem[k][j]), .quo_out (dv_quo[k][j])
                );
            end else begin : g_next
                qslerp_div_cell u_cell (
                    .aclk (aclk), .en (adv), .idx (4'(DIV_STEPS - 1 - j)),
                    .den (side_reg[ST_DIV0-1+j].sn),
                    .rem_in (dv_rem[k][j-1]), .quo_in (dv_quo[k][j-1]),
                    .rem_out (dv_rem[k][j]), .quo_out (dv_quo[k][j])
                );
            end
        end
    end

    // A degenerate result carries the start quaternion unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == side_reg[ST_OUT].s)
        else $error("degenerate result does not match start");

    // A non-degenerate item never divides by zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_OUT] && !side_reg[ST_OUT].degen |-> side_reg[ST_OUT].sn != 31'd0)
        else $error("division by zero reached the output");

    // Theta stays in [0, pi].
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_TH] |-> side_reg[ST_TH].theta <= Q30_PI)
        else $error("theta out of range");

    // Both sine angles are folded into [0, pi/2].
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_ANG] |-> {1'b0, ang_a_reg} <= Q30_HALF_PI
                            && {1'b0, ang_b_reg} <= Q30_HALF_PI)
        else $error("sine angle not folded");

endmodule

[dv/quaternion_slerp_unit_tb.sv]
// Self-checking stream testbench for the fixed-point quaternion slerp unit.
`timescale 1ns / 1ps

module quaternion_slerp_unit_tb;
    import qslerp_pkg::*;

    localparam int DRAIN_CYCLES = 130;
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        logic signed [15:0] s[4];
        logic signed [15:0] f[4];
        logic [14:0]        blend;
    } slerp_req_t;

    typedef struct {
        logic signed [15:0] q[4];
        logic               degen;
    } slerp_res_t;

    typedef struct {
        slerp_req_t req;
        bit         typed;
        slerp_res_t res;
    } table_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // start_w, start_x, start_y, start_z, finish_w, finish_x, finish_y, finish_z,
    // blend (15 bits), one pad bit
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // out_w, out_x, out_y, out_z
    logic [63:0]  m_tdata;
    // degenerate
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [12:0]  cfg_data;

    quaternion_slerp_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Predictor copy of the threshold register.
    logic [12:0]  angle_limit;
    slerp_res_t   pending_results[$];
    slerp_res_t   cur_typed_res;
    bit           cur_typed;
    int           error_count;
    int           results_seen;
    int           degen_seen;
    int           hold_cycles;
    int           idle_cycles;
    bit           receiver_busy_mode;

    longint atan_tab[CORDIC_ITER] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Angle of the vector (x, y) in Q30 radians.
    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < CORDIC_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
        end
        return z;
    endfunction

    // Sine of an angle in [0, pi], Q30 in and out, clamped to [0, 1].
    function automatic longint rotate_sine(input longint a);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(CORDIC_GAIN);
        y = 0;
        if (a > longint'(Q30_HALF_PI)) a = longint'(Q30_PI) - a;
        z = a;
        for (int i = 0; i < CORDIC_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
        end
        if (y < 0) y = 0;
        if (y > longint'(Q30_ONE)) y = longint'(Q30_ONE);
        return y;
    endfunction

    function automatic slerp_res_t slerp_predict(input slerp_req_t r, input logic [12:0] lim);
        slerp_res_t o;
        longint dot;
        longint mag;
        longint sn;
        longint theta;
        longint t;
        longint u;
        longint sa;
        longint sb;
        longint num;
        longint m;
        longint q;
        bit     neg;
        dot = 0;
        for (int k = 0; k < 4; k++) dot = dot + longint'(r.s[k]) * longint'(r.f[k]);
        neg = dot < 0;
        mag = neg ? -dot : dot;
        if (mag >= (longint'(1) << (2 * FRAC_BITS))) mag = longint'(Q30_ONE);
        else mag = mag << MAG_SHIFT;
        sn = longint'(int_sqrt((64'd1 << 60) - 64'(mag * mag)));
        o.degen = (sn == 0) || (sn < (longint'(lim) << LIM_SHIFT));
        if (o.degen) begin
            o.q = r.s;
            return o;
        end
        theta = vector_angle(mag, sn);
        if (neg) theta = longint'(Q30_PI) - theta;
        if (theta < 0) theta = 0;
        if (theta > longint'(Q30_PI)) theta = longint'(Q30_PI);
        t = longint'(r.blend);
        if (t > longint'(BLEND_ONE)) t = longint'(BLEND_ONE);
        u = longint'(BLEND_ONE) - t;
        sa = rotate_sine((u * theta) >>> FRAC_BITS);
        sb = rotate_sine((t * theta) >>> FRAC_BITS);
        for (int k = 0; k < 4; k++) begin
            num = longint'(r.s[k]) * sa + longint'(r.f[k]) * sb;
            m = num < 0 ? -num : num;
            q = (m + sn / 2) / sn;
            if (num < 0) q = -q;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            o.q[k] = 16'(q);
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d", results_seen, what, got, want);
        error_count++;
    endtask

    // Request and result tracking, sampled at the rising edge.
    always @(posedge aclk) begin
        slerp_req_t r;
        slerp_res_t e;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) angle_limit = cfg_data;
            if (s_tvalid && s_tready) begin
                for (int k = 0; k < 4; k++) begin
                    r.s[k] = s_tdata[16*k +: 16];
                    r.f[k] = s_tdata[64 + 16*k +: 16];
                end
                r.blend = s_tdata[142:128];
                pending_results.push_back(cur_typed ? cur_typed_res
                                                    : slerp_predict(r, angle_limit));
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("results pending", 0, 1);
                end else begin
                    e = pending_results.pop_front();
                    for (int k = 0; k < 4; k++)
                        if ($signed(m_tdata[16*k +: 16]) != e.q[k])
                            report_mismatch($sformatf("component %0d", k),
                                            $signed(m_tdata[16*k +: 16]), e.q[k]);
                    if (m_tuser[0] != e.degen)
                        report_mismatch("degenerate", m_tuser[0], e.degen);
                    if (e.degen) degen_seen++;
                end
                results_seen++;
            end
        end
    end

    // Watchdog on cycles without any accepted transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("quaternion_slerp_unit_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result-side stall pattern, with an optional long hold-off.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (receiver_busy_mode) begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input slerp_req_t r, input bit typed, input slerp_res_t res);
        @(negedge aclk);
        s_tvalid      <= 1'b1;
        s_tdata       <= {1'b0, r.blend, r.f[3], r.f[2], r.f[1], r.f[0],
                          r.s[3], r.s[2], r.s[1], r.s[0]};
        cur_typed     <= typed;
        cur_typed_res <= res;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid for a random gap; called between bursts.
    task automatic sender_gap(input int len);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (len) @(negedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [12:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_comp();
        return 16'($urandom);
    endfunction

    // Random quaternion of unit length, optionally near a given one.
    function automatic void unit_quat(output logic signed [15:0] q[4],
                                      input logic signed [15:0] near[4], input int spread);
        real v[4];
        real n;
        n = 0.0;
        for (int k = 0; k < 4; k++) begin
            if (spread > 0)
                v[k] = real'(near[k]) + real'($urandom_range(0, 2 * spread)) - real'(spread);
            else
                v[k] = real'($urandom_range(0, 32768)) - 16384.0;
            n = n + v[k] * v[k];
        end
        if (n < 1.0) begin
            v[0] = 16384.0;
            n = 16384.0 * 16384.0;
        end
        n = $sqrt(n);
        for (int k = 0; k < 4; k++) q[k] = 16'($rtoi(v[k] * 16384.0 / n));
    endfunction

    function automatic slerp_req_t random_request();
        slerp_req_t r;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // Raw noise over the full component range.
            for (int k = 0; k < 4; k++) begin
                r.s[k] = rand_comp();
                r.f[k] = rand_comp();
            end
        end else begin
            unit_quat(r.s, r.s, 0);
            if (kind < 5) unit_quat(r.f, r.s, $urandom_range(1, 3000));
            else unit_quat(r.f, r.s, 0);
            if (kind == 9)
                for (int k = 0; k < 4; k++) r.f[k] = -r.f[k];
        end
        if ($urandom_range(0, 9) == 0) r.blend = 15'($urandom);
        else r.blend = 15'($urandom_range(0, 16384));
        return r;
    endfunction

    function automatic table_row_t make_row(input int sw, sx, sy, sz, fw, fx, fy, fz, bl,
                                            input bit typed, input int ow, ox, oy, oz,
                                            input bit dg);
        table_row_t row;
        row.req.s = '{16'(sw), 16'(sx), 16'(sy), 16'(sz)};
        row.req.f = '{16'(fw), 16'(fx), 16'(fy), 16'(fz)};
        row.req.blend = 15'(bl);
        row.typed = typed;
        row.res.q = '{16'(ow), 16'(ox), 16'(oy), 16'(oz)};
        row.res.degen = dg;
        return row;
    endfunction

    task automatic random_phase(input int n_items);
        int burst;
        burst = $urandom_range(1, 40);
        for (int i = 0; i < n_items; i++) begin
            send_request(random_request(), 1'b0, cur_typed_res);
            burst--;
            if (burst == 0) begin
                if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
        end
        wait_drained();
    endtask

    initial begin
        table_row_t  directed[$];
        logic [12:0] limits[$];
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        m_tready           = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        cur_typed          = 1'b0;
        angle_limit        = 13'd16;
        error_count        = 0;
        results_seen       = 0;
        degen_seen         = 0;
        hold_cycles        = 0;
        idle_cycles        = 0;
        receiver_busy_mode = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed stimulus: identical and opposite inputs, extremes, blend edges.
        directed.push_back(make_row(16384, 0, 0, 0, 16384, 0, 0, 0, 8192,
                                    1, 16384, 0, 0, 0, 1));
        directed.push_back(make_row(16384, 0, 0, 0, -16384, 0, 0, 0, 8192,
                                    1, 16384, 0, 0, 0, 1));
        directed.push_back(make_row(-32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, -32768, 0,
                                    1, -32768, -32768, -32768, -32768, 1));
        directed.push_back(make_row(32767, 32767, 32767, 32767,
                                    -32768, -32768, -32768, -32768, 32767,
                                    1, 32767, 32767, 32767, 32767, 1));
        directed.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 0, 16384, 1, 0, 0, 0, 0, 0));
        directed.push_back(make_row(16384, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(16384, 0, 0, 0, 0, 16384, 0, 0, 8192, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(16384, 0, 0, 0, 0, 16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(16384, 0, 0, 0, 0, 16384, 0, 0, 32767, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(16384, 0, 0, 0, 16383, 181, 0, 0, 4096, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(16384, 0, 0, 0, -16383, 181, 0, 0, 12288, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(0, 0, 16384, 0, 0, 0, 0, -16384, 5461, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(32767, -32768, 100, -100, 1, -1, 32767, -32768, 16000,
                                    0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(8192, 8192, 8192, 8192, 8192, -8192, 8192, -8192, 1,
                                    0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(2000, 0, 0, 0, 0, 3000, 0, 0, 16383, 0, 0, 0, 0, 0, 0));
        foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].res);
        wait_drained();

        // Back-pressure: long hold-off with the sender still offering requests.
        receiver_busy_mode = 1'b1;
        hold_cycles = LONG_HOLD;
        random_phase(300);

        // Threshold settings, extremes included; the highest one stays short.
        limits = '{13'd0, 13'd4096, 13'd8191, 13'd1, 13'($urandom_range(0, 4096)), 13'd16};
        foreach (limits[i]) begin
            write_limit(limits[i]);
            receiver_busy_mode = (i % 2 == 0);
            random_phase(limits[i] == 13'd8191 ? 60 : 230);
        end

        $display("Covered %0d results (%0d degenerate) over %0d threshold settings,",
                 results_seen, degen_seen, limits.size() + 1);
        $display("with bursty input, random and long output stalls.");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("quaternion_slerp_unit_tb: clean");
        end else begin
            $display("quaternion_slerp_unit_tb: errors");
        end
        $finish;
    end

endmodule

[files.f]
design/qslerp_pkg.sv
design/qslerp_sqrt_cell.sv
design/qslerp_cordic_cell.sv
design/qslerp_div_cell.sv
design/quaternion_slerp_unit.sv
dv/quaternion_slerp_unit_tb.sv
